// ===== sv/acs_pkg.sv =====
package acs_pkg;

  localparam logic [15:0] LETTER_BASE  = 16'h0621;
  localparam logic [15:0] LETTER_LAST  = 16'h064A;
  localparam int          LETTER_COUNT = 42;
  localparam int          FORM_COUNT   = 4;
  localparam int          ROW_W        = 6;

  // form table columns
  typedef enum logic [1:0] {
    COL_FINAL    = 2'd0,
    COL_INITIAL  = 2'd1,
    COL_MEDIAL   = 2'd2,
    COL_ISOLATED = 2'd3
  } form_col_t;

  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] row;
  } letter_t;

  typedef struct packed {
    logic [15:0] glyph;
    logic        last_glyph;
  } glyph_word_t;

  // columns: final, initial, medial, isolated
  localparam logic [15:0] FORMS [LETTER_COUNT][FORM_COUNT] = '{
    '{16'hFE80, 16'hFE80, 16'hFE80, 16'hFE80}, '{16'hFE82, 16'hFE81, 16'hFE82, 16'hFE81},
    '{16'hFE84, 16'hFE83, 16'hFE84, 16'hFE83}, '{16'hFE86, 16'hFE85, 16'hFE86, 16'hFE85},
    '{16'hFE88, 16'hFE87, 16'hFE88, 16'hFE87}, '{16'hFE8A, 16'hFE8B, 16'hFE8C, 16'hFE89},
    '{16'hFE8E, 16'hFE8D, 16'hFE8E, 16'hFE8D}, '{16'hFE90, 16'hFE91, 16'hFE92, 16'hFE8F},
    '{16'hFE94, 16'hFE93, 16'hFE94, 16'hFE93}, '{16'hFE96, 16'hFE97, 16'hFE98, 16'hFE95},
    '{16'hFE9A, 16'hFE9B, 16'hFE9C, 16'hFE99}, '{16'hFE9E, 16'hFE9F, 16'hFEA0, 16'hFE9D},
    '{16'hFEA2, 16'hFEA3, 16'hFEA4, 16'hFEA1}, '{16'hFEA6, 16'hFEA7, 16'hFEA8, 16'hFEA5},
    '{16'hFEAA, 16'hFEA9, 16'hFEAA, 16'hFEA9}, '{16'hFEAC, 16'hFEAB, 16'hFEAC, 16'hFEAB},
    '{16'hFEAE, 16'hFEAD, 16'hFEAE, 16'hFEAD}, '{16'hFEB0, 16'hFEAF, 16'hFEB0, 16'hFEAF},
    '{16'hFEB2, 16'hFEB3, 16'hFEB4, 16'hFEB1}, '{16'hFEB6, 16'hFEB7, 16'hFEB8, 16'hFEB5},
    '{16'hFEBA, 16'hFEBB, 16'hFEBC, 16'hFEB9}, '{16'hFEBE, 16'hFEBF, 16'hFEC0, 16'hFEBD},
    '{16'hFEC2, 16'hFEC3, 16'hFEC4, 16'hFEC1}, '{16'hFEC6, 16'hFEC7, 16'hFEC8, 16'hFEC5},
    '{16'hFECA, 16'hFECB, 16'hFECC, 16'hFEC9}, '{16'hFECE, 16'hFECF, 16'hFED0, 16'hFECD},
    '{16'h063B, 16'h063B, 16'h063B, 16'h063B}, '{16'h063C, 16'h063C, 16'h063C, 16'h063C},
    '{16'h063D, 16'h063D, 16'h063D, 16'h063D}, '{16'h063E, 16'h063E, 16'h063E, 16'h063E},
    '{16'h063F, 16'h063F, 16'h063F, 16'h063F}, '{16'h0640, 16'h0640, 16'h0640, 16'h0640},
    '{16'hFED2, 16'hFED3, 16'hFED4, 16'hFED1}, '{16'hFED6, 16'hFED7, 16'hFED8, 16'hFED5},
    '{16'hFEDA, 16'hFEDB, 16'hFEDC, 16'hFED9}, '{16'hFEDE, 16'hFEDF, 16'hFEE0, 16'hFEDD},
    '{16'hFEE2, 16'hFEE3, 16'hFEE4, 16'hFEE1}, '{16'hFEE6, 16'hFEE7, 16'hFEE8, 16'hFEE5},
    '{16'hFEEA, 16'hFEEB, 16'hFEEC, 16'hFEE9}, '{16'hFEEE, 16'hFEED, 16'hFEEE, 16'hFEED},
    '{16'hFEF0, 16'hFEF3, 16'hFEF4, 16'hFEEF}, '{16'hFEF2, 16'hFEF3, 16'hFEF4, 16'hFEF1}
  };

  // table row of a character; the lowest matching row wins
  function automatic letter_t letter_of(input logic [15:0] c);
    letter_t res;
    res.hit = 1'b0;
    res.row = '0;
    for (int r = LETTER_COUNT - 1; r >= 0; r--) begin
      for (int k = 0; k < FORM_COUNT; k++) begin
        if (FORMS[r][k] == c) begin
          res.hit = 1'b1;
          res.row = ROW_W'(r);
        end
      end
    end
    if (c >= LETTER_BASE && c <= LETTER_LAST) begin
      res.hit = 1'b1;
      res.row = ROW_W'(c - LETTER_BASE);
    end
    return res;
  endfunction

endpackage

// ===== sv/acs_if.sv =====
interface acs_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic        end_of_text;

  modport source (output valid, output code_point, output end_of_text, input ready);
  modport sink   (input valid, input code_point, input end_of_text, output ready);
endinterface

interface acs_glyph_if;
  logic        valid;
  logic        ready;
  logic [15:0] glyph;
  logic        last_glyph;

  modport source (output valid, output glyph, output last_glyph, input ready);
  modport sink   (input valid, input glyph, input last_glyph, output ready);
endinterface

// ===== sv/acs_form_sel.sv =====
module acs_form_sel (
  input  logic [15:0]      code,
  input  acs_pkg::letter_t info,
  input  logic             prev,
  input  logic             next,
  input  logic             enable,
  output logic [15:0]      glyph
);
  import acs_pkg::*;

  form_col_t col;

  always_comb begin
    if (prev && next) begin
      col = COL_MEDIAL;
    end else if (next) begin
      col = COL_INITIAL;
    end else if (prev) begin
      col = COL_FINAL;
    end else begin
      col = COL_ISOLATED;
    end
  end

  assign glyph = (enable && info.hit) ? FORMS[info.row][col] : code;

endmodule

// ===== sv/arabic_contextual_shaper.sv =====
// channel   | dir | word                        | handshake
// chars     | in  | code_point[15:0], end_of_text | valid/ready
// glyphs    | out | glyph[15:0], last_glyph      | valid/ready
// cfg       | in  | cfg_data (shaping_enable)    | cfg_write, no wait
//
// One character per cycle while chars.ready is high. A character without end_of_text
// releases the glyph held before it, if any; a character with end_of_text releases up
// to two, but each character yields exactly one glyph, so the four-word result queue
// absorbs that burst and a receiver that is always ready never stalls chars.
// Reset (rst, synchronous) clears the held character, join context and queue, and enables shaping.
// chars.ready depends only on queue fill: it stays high while two words fit.
module arabic_contextual_shaper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  acs_char_if.sink    chars,
  acs_glyph_if.source glyphs
);
  import acs_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  logic              shaping_enable;
  logic [15:0]       held_char;
  letter_t           held_info;
  logic              held_valid;
  logic              before_joins;

  glyph_word_t       queue [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  letter_t           cur_info;
  logic              cur_prev;
  logic [15:0]       held_glyph;
  logic [15:0]       cur_glyph;
  logic              accept;
  logic              pop;
  logic [QCNT_W-1:0] push_n;
  logic [QPTR_W-1:0] second_addr;

  assign cur_info = letter_of(chars.code_point);
  assign cur_prev = held_valid ? held_info.hit : before_joins;

  acs_form_sel u_held_form (
    .code   (held_char),
    .info   (held_info),
    .prev   (before_joins),
    .next   (cur_info.hit),
    .enable (shaping_enable),
    .glyph  (held_glyph)
  );

  // last character of a string never joins after
  acs_form_sel u_cur_form (
    .code   (chars.code_point),
    .info   (cur_info),
    .prev   (cur_prev),
    .next   (1'b0),
    .enable (shaping_enable),
    .glyph  (cur_glyph)
  );

  assign chars.ready = (count <= QCNT_W'(QDEPTH - 2));
  assign accept      = chars.valid && chars.ready;
  assign pop         = glyphs.valid && glyphs.ready;
  assign push_n      = accept ? (QCNT_W'(held_valid) + QCNT_W'(chars.end_of_text)) : '0;
  assign second_addr = wptr + QPTR_W'(held_valid);
  assign count_next  = count + push_n - QCNT_W'(pop);

  assign glyphs.valid      = (count != '0);
  assign glyphs.glyph      = queue[rptr].glyph;
  assign glyphs.last_glyph = queue[rptr].last_glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      shaping_enable <= 1'b1;
      held_valid     <= 1'b0;
      before_joins   <= 1'b0;
      wptr           <= '0;
      rptr           <= '0;
      count          <= '0;
    end else begin
      if (cfg_write) begin
        shaping_enable <= cfg_data;
      end
      if (accept) begin
        if (chars.end_of_text) begin
          // flush and drop the join context
          held_valid   <= 1'b0;
          before_joins <= 1'b0;
        end else begin
          held_valid   <= 1'b1;
          before_joins <= cur_prev;
        end
      end
      wptr  <= wptr + QPTR_W'(push_n);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!chars.end_of_text) begin
        held_char <= chars.code_point;
        held_info <= cur_info;
      end
      if (held_valid) begin
        queue[wptr] <= '{glyph: held_glyph, last_glyph: 1'b0};
      end
      if (chars.end_of_text) begin
        queue[second_addr] <= '{glyph: cur_glyph, last_glyph: 1'b1};
      end
    end
  end

endmodule

// ===== sv/acs_checker.sv =====
module acs_checker (
  input logic        clk,
  input logic        rst,
  input logic        chars_valid,
  input logic        chars_ready,
  input logic        chars_end_of_text,
  input logic        glyph_valid,
  input logic        glyph_ready,
  input logic [15:0] glyph,
  input logic        last_glyph
);

  // queue empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !glyph_valid)
    else $error("glyph word present right after reset");

  // an empty queue always has room for a character
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !glyph_valid |-> chars_ready)
    else $error("chars stalled while no glyph is pending");

  // end of text always releases at least one glyph
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (chars_valid && chars_ready && chars_end_of_text) |=> glyph_valid)
    else $error("no glyph after end of text");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (glyph_valid && !glyph_ready) |=>
      (glyph_valid && $stable(glyph) && $stable(last_glyph)))
    else $error("stalled glyph word changed");

endmodule

bind arabic_contextual_shaper acs_checker u_acs_checker (
  .clk               (clk),
  .rst               (rst),
  .chars_valid       (chars.valid),
  .chars_ready       (chars.ready),
  .chars_end_of_text (chars.end_of_text),
  .glyph_valid       (glyphs.valid),
  .glyph_ready       (glyphs.ready),
  .glyph             (glyphs.glyph),
  .last_glyph        (glyphs.last_glyph)
);
